FILE: src/base64_stream_encoder_core_assert.svh
// Assertion macros for the base64 stream encoder.
// Both expect signals named clk and arst_n in the scope where they are used.
`ifndef BASE64_STREAM_ENCODER_CORE_ASSERT_SVH
`define BASE64_STREAM_ENCODER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B64ENC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("b64enc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define B64ENC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("b64enc: next-cycle check failed");

`endif

FILE: src/b64enc_pkg.sv
`timescale 1ns / 1ps

package b64enc_pkg;

	localparam int unsigned SLOTS = 4;
	localparam logic [6:0] PAD_CHAR = 7'd61;

	// One output character before ASCII mapping: a 6-bit group or a pad.
	typedef struct packed {
		logic       pad;
		logic [5:0] idx;
	} code_t;

	// Everything one input byte produces, handed from front to back.
	typedef struct packed {
		code_t [SLOTS-1:0] code;
		logic [1:0]        last_slot;
		logic              final_flag;
	} entry_t;

	function automatic logic [6:0] b64_char(input logic [5:0] idx);
		logic [6:0] c;
		if (idx < 6'd26) begin
			c = 7'd65 + {1'b0, idx};
		end else if (idx < 6'd52) begin
			c = 7'd71 + {1'b0, idx};
		end else if (idx < 6'd62) begin
			c = {1'b0, idx} - 7'd4;
		end else if (idx == 6'd62) begin
			c = 7'd43;
		end else begin
			c = 7'd47;
		end
		return c;
	endfunction

endpackage

FILE: src/b64enc_if.sv
`timescale 1ns / 1ps

interface b64enc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface b64enc_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       out_final;

	modport source (output valid, output out_char, output out_final, input ready);
	modport sink (input valid, input out_char, input out_final, output ready);
endinterface

FILE: src/base64_stream_encoder_core.sv
`timescale 1ns / 1ps
// Channel   | Modport | Beat payload                | Role
// byte_in   | sink    | data_byte, end_of_stream    | raw bytes, last byte flagged
// char_out  | source  | out_char, out_final         | Base64 characters, last one flagged
//
// One character leaves per cycle from the output register while char_out is ready; each byte makes one to four.
// A byte is taken in the cycle it arrives while the two-entry queue has room, so the
// character serializer sets the sustained rate.
// A byte's first character passes through its queue entry and then the output register.
// arst_n clears the bit store, the queue and the output valid; no clearing pass.
// A stall on char_out holds the output register and backs up into the queue.
module base64_stream_encoder_core (
	input  logic         clk,
	input  logic         arst_n,
	b64enc_in_if.sink    byte_in,
	b64enc_out_if.source char_out
);

	logic               push_valid;
	logic               push_ready;
	b64enc_pkg::entry_t push_entry;
	logic               head_valid;
	b64enc_pkg::entry_t head;
	logic               pop;

	b64enc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_in),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	b64enc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (head_valid),
		.pop_entry  (head),
		.pop        (pop)
	);

	b64enc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.char_out   (char_out)
	);

endmodule

FILE: src/b64enc_front.sv
`timescale 1ns / 1ps

module b64enc_front (
	input  logic                clk,
	input  logic                arst_n,
	b64enc_in_if.sink           byte_in,
	output logic                push_valid,
	output b64enc_pkg::entry_t  push_entry,
	input  logic                push_ready
);

	localparam logic [2:0] CNT_0 = 3'd0;
	localparam logic [2:0] CNT_2 = 3'd2;
	localparam logic [2:0] CNT_4 = 3'd4;

	logic [3:0] pending_bits_q;
	logic [2:0] pending_count_q;
	logic [1:0] char_phase_q;

	logic       accept;
	logic       last;
	logic [7:0] b;
	logic [5:0] d0;
	logic [5:0] d1;
	logic       two;
	logic [3:0] rem;
	logic [2:0] ncnt;
	logic [5:0] part_idx;
	logic       has_part;
	logic [1:0] ndata;
	logic [1:0] part_pos;
	logic [1:0] phase_end;
	logic [1:0] pads;
	logic [2:0] total;

	assign b          = byte_in.data_byte;
	assign last       = byte_in.end_of_stream;
	assign push_valid = byte_in.valid;
	assign byte_in.ready = push_ready;
	assign accept     = byte_in.valid && push_ready;

	always_comb begin
		d1   = '0;
		two  = 1'b0;
		case (pending_count_q)
			CNT_0: begin
				d0   = b[7:2];
				rem  = {2'b00, b[1:0]};
				ncnt = CNT_2;
			end
			CNT_2: begin
				d0   = {pending_bits_q[1:0], b[7:4]};
				rem  = b[3:0];
				ncnt = CNT_4;
			end
			default: begin
				d0   = {pending_bits_q[3:0], b[7:6]};
				d1   = b[5:0];
				two  = 1'b1;
				rem  = 4'd0;
				ncnt = CNT_0;
			end
		endcase

		// zero-fill the leftover bits on the right
		part_idx  = (ncnt == CNT_2) ? {rem[1:0], 4'd0} : {rem[3:0], 2'd0};
		has_part  = last && (ncnt != CNT_0);
		ndata     = two ? 2'd2 : 2'd1;
		part_pos  = ndata;
		phase_end = 2'(char_phase_q + ndata + {1'b0, has_part});
		pads      = 2'(2'd0 - phase_end);
		total     = {1'b0, ndata} + {2'b00, has_part} + {1'b0, pads};

		for (int i = 0; i < b64enc_pkg::SLOTS; i++) begin
			push_entry.code[i].pad = 1'b1;
			push_entry.code[i].idx = '0;
			if (i == 0) begin
				push_entry.code[i].pad = 1'b0;
				push_entry.code[i].idx = d0;
			end else if (i == 1 && two) begin
				push_entry.code[i].pad = 1'b0;
				push_entry.code[i].idx = d1;
			end else if (2'(i) == part_pos && has_part) begin
				push_entry.code[i].pad = 1'b0;
				push_entry.code[i].idx = part_idx;
			end
		end

		if (!last) begin
			push_entry.last_slot = two ? 2'd1 : 2'd0;
		end else if (total >= 3'd4) begin
			push_entry.last_slot = 2'd3;
		end else begin
			push_entry.last_slot = 2'(total - 3'd1);
		end
		push_entry.final_flag = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_bits_q  <= '0;
			pending_count_q <= CNT_0;
			char_phase_q    <= '0;
		end else if (accept) begin
			if (last) begin
				pending_bits_q  <= '0;
				pending_count_q <= CNT_0;
				char_phase_q    <= '0;
			end else begin
				pending_bits_q  <= rem;
				pending_count_q <= ncnt;
				char_phase_q    <= 2'(char_phase_q + ndata);
			end
		end
	end

endmodule

FILE: src/b64enc_queue.sv
`timescale 1ns / 1ps

module b64enc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  b64enc_pkg::entry_t  push_entry,
	output logic                pop_valid,
	output b64enc_pkg::entry_t  pop_entry,
	input  logic                pop
);

	b64enc_pkg::entry_t mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: src/b64enc_back.sv
`timescale 1ns / 1ps

module b64enc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  b64enc_pkg::entry_t  head,
	output logic                pop,
	b64enc_out_if.source        char_out
);

	logic [1:0] slot_q;
	logic       out_valid_q;
	logic [6:0] char_q;
	logic       final_q;
	logic       load;
	logic       at_last;
	b64enc_pkg::code_t cur;

	assign cur     = head.code[slot_q];
	assign at_last = (slot_q == head.last_slot);
	assign load    = head_valid && (!out_valid_q || char_out.ready);
	assign pop     = load && at_last;

	assign char_out.valid     = out_valid_q;
	assign char_out.out_char  = char_q;
	assign char_out.out_final = final_q;

	always_ff @(posedge clk) begin
		if (load) begin
			char_q  <= cur.pad ? b64enc_pkg::PAD_CHAR : b64enc_pkg::b64_char(cur.idx);
			final_q <= head.final_flag && at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				// advance through the entry, drop it after its last character
				slot_q      <= at_last ? 2'd0 : slot_q + 2'd1;
			end else if (char_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/b64enc_checker.sv
`timescale 1ns / 1ps
`include "base64_stream_encoder_core_assert.svh"

module b64enc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] out_char,
	input logic       out_final
);

	logic [1:0] chars_q;
	logic       pad_open_q;
	logic       out_beat;
	logic       legal;

	assign out_beat = out_valid && out_ready;
	assign legal = (out_char >= 7'd65 && out_char <= 7'd90)
		|| (out_char >= 7'd97 && out_char <= 7'd122)
		|| (out_char >= 7'd48 && out_char <= 7'd57)
		|| (out_char == 7'd43) || (out_char == 7'd47)
		|| (out_char == b64enc_pkg::PAD_CHAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q    <= '0;
			pad_open_q <= 1'b0;
		end else if (out_beat) begin
			if (out_final) begin
				chars_q    <= '0;
				pad_open_q <= 1'b0;
			end else begin
				chars_q    <= chars_q + 2'd1;
				pad_open_q <= (out_char == b64enc_pkg::PAD_CHAR);
			end
		end
	end

	`B64ENC_ASSERT_NOW(a_legal_char, out_valid, legal)
	`B64ENC_ASSERT_NOW(a_final_on_quad, out_beat && out_final, chars_q == 2'd3)
	`B64ENC_ASSERT_NOW(a_pad_runs_to_end, out_valid && pad_open_q, out_char == b64enc_pkg::PAD_CHAR)
	`B64ENC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(out_final))

endmodule

bind base64_stream_encoder_core b64enc_checker u_b64enc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (char_out.valid),
	.out_ready (char_out.ready),
	.out_char  (char_out.out_char),
	.out_final (char_out.out_final)
);

FILE: verif/base64_stream_encoder_core_tb.sv
`timescale 1ns / 1ps

module base64_stream_encoder_core_tb;

	localparam logic [511:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam int HOLD_OFF_CYCLES = 100;
	localparam int DRAIN_CYCLES    = 8;

	typedef struct packed {
		logic [6:0] ch;
		logic       is_last;
	} b64_char_t;

	logic clk;
	logic arst_n;

	b64enc_in_if  byte_in ();
	b64enc_out_if char_out ();

	base64_stream_encoder_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_in.sink),
		.char_out (char_out.source)
	);

	// Encoder state mirrored on the testbench side
	logic [3:0] enc_bits;
	logic [2:0] enc_count;
	logic [1:0] enc_phase;
	b64_char_t  expected_chars[$];

	bit src_idle_en;
	bit snk_idle_en;
	int hold_off_reqs;
	int mismatches;
	int bytes_sent;
	int streams_sent;
	int chars_checked;
	int pads_checked;
	int in_stall_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[base64_stream_encoder_core] ERROR");
		$finish;
	end

	function automatic logic [6:0] b64_ascii(input logic [5:0] idx);
		return B64_ALPHABET[8 * (63 - int'(idx)) +: 7];
	endfunction

	// Queue the characters one byte produces and advance the mirrored state.
	function automatic void encode_byte(input logic [7:0] b, input logic eos);
		logic [11:0] acc;
		logic [6:0]  chars[4];
		logic [5:0]  idx;
		int unsigned nbits;
		int          n;
		acc = {enc_bits, b};
		nbits = enc_count + 8;
		n = 0;
		while (nbits >= 6) begin
			nbits -= 6;
			idx = 6'(acc >> nbits);
			chars[n] = b64_ascii(idx);
			n++;
			enc_phase++;
		end
		enc_bits = 4'(acc & ((12'd1 << nbits) - 12'd1));
		enc_count = 3'(nbits);
		if (eos) begin
			// flush the leftover bits zero-filled on the right, then pad to a quad
			if (nbits > 0) begin
				idx = 6'({2'b00, enc_bits} << (6 - nbits));
				chars[n] = b64_ascii(idx);
				n++;
				enc_phase++;
			end
			while (enc_phase != 2'd0 && n < 4) begin
				chars[n] = b64enc_pkg::PAD_CHAR;
				n++;
				enc_phase++;
			end
		end
		for (int i = 0; i < n; i++)
			expected_chars.insert(expected_chars.size(),
				'{ch: chars[i], is_last: eos && (i == n - 1)});
		if (eos) begin
			enc_bits = '0;
			enc_count = '0;
			enc_phase = '0;
		end
	endfunction

	task automatic send_beat(input logic [7:0] b, input logic eos);
		while (src_idle_en && $urandom_range(99) < 7) begin
			byte_in.valid <= 1'b0;
			@(posedge clk);
		end
		byte_in.valid <= 1'b1;
		byte_in.data_byte <= b;
		byte_in.end_of_stream <= eos;
		@(posedge clk);
		while (!byte_in.ready) @(posedge clk);
		encode_byte(b, eos);
		bytes_sent++;
		if (eos)
			streams_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], i == s.len() - 1);
	endtask

	task automatic send_bytes(input logic [7:0] q[$]);
		foreach (q[i])
			send_beat(q[i], i == q.size() - 1);
	endtask

	task automatic send_random_stream(input int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(9))
				0: b = 8'h00;
				1: b = 8'hFF;
				default: b = 8'($urandom_range(255));
			endcase
			send_beat(b, i == len - 1);
		end
	endtask

	task automatic park_source();
		byte_in.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random_streams(input int n_bytes);
		int sent;
		int len;
		sent = 0;
		while (sent < n_bytes) begin
			len = ($urandom_range(9) < 8) ? $urandom_range(12, 1) : $urandom_range(48, 13);
			if (len > n_bytes - sent)
				len = n_bytes - sent;
			send_random_stream(len);
			sent += len;
		end
	endtask

	// Short strings f to fooba: one and two leftover-byte cases and a full quad.
	task automatic test_known_strings();
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		send_text("f");
		send_text("fo");
		send_text("foo");
		send_text("foob");
		send_text("fooba");
		park_source();
	endtask

	// All-zero and all-one bytes, and the two symbols at the top of the alphabet.
	task automatic test_byte_extremes();
		send_bytes('{8'h00});
		send_bytes('{8'hFF});
		send_bytes('{8'hFB, 8'hEF, 8'hBE});
		send_bytes('{8'hFF, 8'hFF, 8'hFF});
		park_source();
	endtask

	task automatic test_random_streams(input int n_bytes);
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		send_random_streams(n_bytes);
		park_source();
	endtask

	task automatic test_back_to_back(input int n_bytes);
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		send_random_streams(n_bytes);
		park_source();
	endtask

	// Hold the sink off while bytes keep coming, so the queue fills and stalls input.
	task automatic test_output_backpressure(input int n_bytes);
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		hold_off_reqs++;
		send_random_streams(n_bytes);
		park_source();
		snk_idle_en = 1'b1;
	endtask

	// Sink side: random stalls, plus a long hold-off on request.
	initial begin : char_sink
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		char_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_off_reqs) begin
				hold_seen = hold_off_reqs;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				char_out.ready <= 1'b0;
				hold_left--;
			end else begin
				char_out.ready <= !(snk_idle_en && $urandom_range(99) < 7);
			end
		end
	end

	always @(posedge clk) begin : check_chars
		b64_char_t want;
		if (arst_n) begin
			if (byte_in.valid && !byte_in.ready)
				in_stall_cycles++;
			if (char_out.valid && char_out.ready) begin
				if (expected_chars.size() == 0) begin
					$error("unexpected beat: out_char=%0d out_final=%0b",
						char_out.out_char, char_out.out_final);
					mismatches++;
				end else begin
					want = expected_chars.pop_front();
					if (char_out.out_char !== want.ch) begin
						$error("out_char: expected %0d, got %0d", want.ch, char_out.out_char);
						mismatches++;
					end
					if (char_out.out_final !== want.is_last) begin
						$error("out_final: expected %0b, got %0b",
							want.is_last, char_out.out_final);
						mismatches++;
					end
					chars_checked++;
					if (want.ch == b64enc_pkg::PAD_CHAR)
						pads_checked++;
				end
			end
		end
	end

	initial begin : main
		enc_bits = '0;
		enc_count = '0;
		enc_phase = '0;
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		hold_off_reqs = 0;
		mismatches = 0;
		bytes_sent = 0;
		streams_sent = 0;
		chars_checked = 0;
		pads_checked = 0;
		in_stall_cycles = 0;
		arst_n <= 1'b0;
		byte_in.valid <= 1'b0;
		byte_in.data_byte <= '0;
		byte_in.end_of_stream <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_known_strings();
		test_byte_extremes();
		test_random_streams(300);
		test_back_to_back(80);
		test_output_backpressure(40);

		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Encoded %0d bytes in %0d streams; %0d characters checked, %0d of them pads.",
			bytes_sent, streams_sent, chars_checked, pads_checked);
		$display("Input held off for %0d cycles under output backpressure.", in_stall_cycles);
		if (mismatches == 0) begin
			$display("[base64_stream_encoder_core] OK");
		end else begin
			$display("[base64_stream_encoder_core] ERROR");
		end
		$finish;
	end

endmodule
